### hw/rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, command codes and types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam int ADDR_W = 11;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CELL_W = 16;

	localparam logic [7:0]        CHAR_NEWLINE = 8'd10;
	localparam logic [7:0]        CHAR_SPACE   = 8'h20;
	localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0500;
	localparam logic [7:0]        COLOR_RESET  = 8'd5;

	localparam logic [2:0] CMD_PUT    = 3'd0;
	localparam logic [2:0] CMD_DELETE = 3'd1;
	localparam logic [2:0] CMD_SWITCH = 3'd2;
	localparam logic [2:0] CMD_CLEAR  = 3'd3;
	localparam logic [2:0] CMD_READ   = 3'd4;

	localparam logic REG_TEXT_COLOR  = 1'b0;
	localparam logic REG_MIRROR_LOCK = 1'b1;

	typedef enum logic [2:0] {
		OP_PUT,
		OP_NEWLINE,
		OP_DELETE,
		OP_SWITCH,
		OP_CLEAR,
		OP_READ,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [7:0]        ch;
		logic              clr_first;
		logic              clr_second;
		logic [ADDR_W-1:0] cell_idx;
	} cmd_t;

endpackage

### hw/rtl/tcw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front
// Accepts input items and classifies them into decoded commands.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; (
	input  logic              push,
	output logic              full,
	input  logic [2:0]        command,
	input  logic [7:0]        char_code,
	input  logic [1:0]        clear_target,
	input  logic [ADDR_W-1:0] cell_index,
	input  logic              q_full,
	input  logic              init_busy,
	output logic              q_wr,
	output cmd_t              q_data
);

	assign full = q_full | init_busy;
	assign q_wr = push & ~full;

	always_comb begin
		q_data            = '0;
		q_data.op         = OP_NOP;
		q_data.ch         = char_code;
		q_data.cell_idx   = cell_index;
		q_data.clr_first  = (clear_target == 2'd1);
		q_data.clr_second = (clear_target == 2'd2);
		unique case (command)
			CMD_PUT:    q_data.op = (char_code == CHAR_NEWLINE) ? OP_NEWLINE : OP_PUT;
			CMD_DELETE: q_data.op = OP_DELETE;
			CMD_SWITCH: q_data.op = OP_SWITCH;
			CMD_CLEAR:  q_data.op = OP_CLEAR;
			// out-of-range reads return zero and touch nothing
			CMD_READ:   q_data.op = (cell_index < ADDR_W'(CELLS)) ? OP_READ : OP_NOP;
			default:    q_data.op = OP_NOP;
		endcase
	end

endmodule

### hw/rtl/tcw_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cmd_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module tcw_cmd_queue import tcw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic valid
);

	cmd_t       slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign valid   = (count_q != 2'd0);
	assign rd_data = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr_en) wptr_q <= ~wptr_q;
			if (rd_en) rptr_q <= ~rptr_q;
			if (wr_en && !rd_en) count_q <= count_q + 2'd1;
			else if (!wr_en && rd_en) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) slot_q[wptr_q] <= wr_data;
	end

endmodule

### hw/rtl/tcw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back
// Executes commands on the cell memories and holds cursor and result state.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  cmd_t              cmd,
	output logic              q_pop,
	output logic              init_busy,
	input  logic              cfg_valid,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data,
	output logic              empty,
	input  logic              pop,
	output logic [CELL_W-1:0] cell_value,
	output logic [COL_W-1:0]  cursor_column,
	output logic [ROW_W-1:0]  cursor_row,
	output logic              active_screen,
	output logic [ADDR_W-1:0] hw_cursor_position
);

	typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_READ, ST_DONE} state_t;
	typedef enum logic [1:0] {SW_INIT, SW_SCROLL, SW_SWITCH, SW_CLEAR} sweep_t;

	localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'(CELLS - COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELLS - 1);
	localparam logic [ROW_W-1:0]  ROW_WRAP      = ROW_W'(ROWS);
	localparam logic [ROW_W-1:0]  ROW_LAST      = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0]  COL_LAST      = COL_W'(COLUMNS - 1);

	logic [CELL_W-1:0] vis_mem [CELLS];
	logic [CELL_W-1:0] fst_mem [CELLS];
	logic [CELL_W-1:0] snd_mem [CELLS];
	logic [CELL_W-1:0] vis_rd_q, fst_rd_q, snd_rd_q;

	state_t            state_q;
	sweep_t            kind_q;
	logic [ADDR_W-1:0] cnt_q;
	logic              valid_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [COL_W-1:0]  col_q, ocol_q;
	logic [ROW_W-1:0]  row_q, orow_q;
	logic              sel_q;
	logic [ADDR_W-1:0] hw_q;
	logic [7:0]        color_q;
	logic              lock_q;
	logic              nl_q;
	logic [7:0]        ch_q;
	logic              clr_first_q, clr_second_q;
	logic [CELL_W-1:0] value_q;
	logic              out_valid_q;
	logic [CELL_W-1:0] out_value_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic              out_sel_q;
	logic [ADDR_W-1:0] out_hw_q;

	logic [ADDR_W-1:0] cur_idx;
	logic [CELL_W-1:0] blank;
	logic              issue;
	logic [ADDR_W-1:0] vis_raddr, sav_raddr;
	logic              vis_we, fst_we, snd_we;
	logic [ADDR_W-1:0] waddr;
	logic [CELL_W-1:0] vis_wdata, sav_wdata, src_cell;
	logic              single_wr;
	logic              at_home;

	assign cur_idx   = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
	assign blank     = {color_q, 8'h00};
	assign issue     = (state_q == ST_SWEEP) && (cnt_q < ADDR_W'(CELLS));
	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign init_busy = (state_q == ST_SWEEP) && (kind_q == SW_INIT);
	assign at_home   = (col_q == '0) && (row_q == '0);
	assign src_cell  = sel_q ? snd_rd_q : fst_rd_q;

	assign single_wr = q_pop && (((cmd.op == OP_PUT) && (row_q != ROW_WRAP))
		|| ((cmd.op == OP_DELETE) && !at_home));

	always_comb begin
		if (q_pop && (cmd.op == OP_READ)) vis_raddr = cmd.cell_idx;
		else if (cnt_q < LAST_ROW_BASE) vis_raddr = cnt_q + ADDR_W'(COLUMNS);
		else vis_raddr = '0;
		sav_raddr = (cnt_q < ADDR_W'(CELLS)) ? cnt_q : '0;
	end

	always_comb begin
		vis_we    = 1'b0;
		fst_we    = 1'b0;
		snd_we    = 1'b0;
		waddr     = addr_s1;
		vis_wdata = blank;
		sav_wdata = blank;
		if (single_wr) begin
			waddr     = (cmd.op == OP_PUT) ? cur_idx : cur_idx - ADDR_W'(1);
			vis_wdata = {color_q, (cmd.op == OP_PUT) ? cmd.ch : CHAR_SPACE};
			sav_wdata = vis_wdata;
			vis_we    = 1'b1;
			fst_we    = !lock_q && !sel_q;
			snd_we    = !lock_q && sel_q;
		end else if (valid_s1) begin
			unique case (kind_q)
				SW_INIT: begin
					vis_wdata = RESET_CELL;
					sav_wdata = RESET_CELL;
					vis_we    = 1'b1;
					fst_we    = 1'b1;
					snd_we    = 1'b1;
				end
				SW_SCROLL: begin
					if (addr_s1 < LAST_ROW_BASE) vis_wdata = vis_rd_q;
					else if (addr_s1 == LAST_ROW_BASE && !nl_q) vis_wdata = {color_q, ch_q};
					else vis_wdata = blank;
					// saved copy takes the current color, lock or not
					sav_wdata = {color_q, vis_wdata[7:0]};
					vis_we    = 1'b1;
					fst_we    = !sel_q;
					snd_we    = sel_q;
				end
				SW_SWITCH: begin
					vis_wdata = {color_q, src_cell[7:0]};
					vis_we    = 1'b1;
				end
				SW_CLEAR: begin
					vis_we = 1'b1;
					fst_we = clr_first_q;
					snd_we = clr_second_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		vis_rd_q <= vis_mem[vis_raddr];
		fst_rd_q <= fst_mem[sav_raddr];
		snd_rd_q <= snd_mem[sav_raddr];
		if (vis_we) vis_mem[waddr] <= vis_wdata;
		if (fst_we) fst_mem[waddr] <= sav_wdata;
		if (snd_we) snd_mem[waddr] <= sav_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			kind_q       <= SW_INIT;
			cnt_q        <= '0;
			valid_s1     <= 1'b0;
			addr_s1      <= '0;
			col_q        <= '0;
			row_q        <= '0;
			ocol_q       <= '0;
			orow_q       <= '0;
			sel_q        <= 1'b0;
			hw_q         <= '0;
			color_q      <= COLOR_RESET;
			lock_q       <= 1'b0;
			nl_q         <= 1'b0;
			ch_q         <= '0;
			clr_first_q  <= 1'b0;
			clr_second_q <= 1'b0;
			value_q      <= '0;
			out_valid_q  <= 1'b0;
			out_value_q  <= '0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			out_sel_q    <= 1'b0;
			out_hw_q     <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_TEXT_COLOR) color_q <= cfg_data;
				if (cfg_index == REG_MIRROR_LOCK) lock_q <= cfg_data[0];
			end
			valid_s1 <= issue;
			addr_s1  <= cnt_q;
			if (issue) cnt_q <= cnt_q + ADDR_W'(1);
			if (pop) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						value_q <= '0;
						ch_q    <= cmd.ch;
						cnt_q   <= '0;
						state_q <= ST_DONE;
						unique case (cmd.op)
							OP_PUT, OP_NEWLINE: begin
								if (row_q == ROW_WRAP || (cmd.op == OP_NEWLINE
										&& row_q == ROW_LAST)) begin
									// scroll, then park the cursor on the last row
									nl_q    <= (cmd.op == OP_NEWLINE);
									kind_q  <= SW_SCROLL;
									state_q <= ST_SWEEP;
									row_q   <= ROW_LAST;
									col_q   <= (cmd.op == OP_NEWLINE) ? '0 : COL_W'(1);
									hw_q    <= (cmd.op == OP_NEWLINE) ? LAST_ROW_BASE
										: LAST_ROW_BASE + ADDR_W'(1);
								end else if (cmd.op == OP_NEWLINE || col_q == COL_LAST) begin
									col_q <= '0;
									row_q <= row_q + ROW_W'(1);
								end else begin
									col_q <= col_q + COL_W'(1);
								end
							end
							OP_DELETE: begin
								if (!at_home) begin
									if (col_q == '0) begin
										col_q <= COL_LAST;
										row_q <= row_q - ROW_W'(1);
									end else begin
										col_q <= col_q - COL_W'(1);
									end
								end
							end
							OP_SWITCH: begin
								col_q   <= ocol_q;
								row_q   <= orow_q;
								ocol_q  <= col_q;
								orow_q  <= row_q;
								sel_q   <= ~sel_q;
								kind_q  <= SW_SWITCH;
								state_q <= ST_SWEEP;
							end
							OP_CLEAR: begin
								clr_first_q  <= cmd.clr_first;
								clr_second_q <= cmd.clr_second;
								if (cmd.clr_first || cmd.clr_second) begin
									col_q <= '0;
									row_q <= '0;
								end
								kind_q  <= SW_CLEAR;
								state_q <= ST_SWEEP;
							end
							OP_READ: state_q <= ST_READ;
							default: ;
						endcase
					end
				end
				ST_SWEEP: begin
					if (valid_s1 && addr_s1 == LAST_CELL)
						state_q <= (kind_q == SW_INIT) ? ST_IDLE : ST_DONE;
				end
				ST_READ: begin
					value_q <= vis_rd_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the result slot frees up
					if (!out_valid_q || pop) begin
						out_valid_q <= 1'b1;
						out_value_q <= value_q;
						out_col_q   <= col_q;
						out_row_q   <= row_q;
						out_sel_q   <= sel_q;
						out_hw_q    <= hw_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign empty              = ~out_valid_q;
	assign cell_value         = out_value_q;
	assign cursor_column      = out_col_q;
	assign cursor_row         = out_row_q;
	assign active_screen      = out_sel_q;
	assign hw_cursor_position = out_hw_q;

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= ROW_WRAP) else $error("cursor row beyond wrap position");
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_LAST) else $error("cursor column beyond last column");
	a_wrap_col: assert property (@(posedge clk) disable iff (!arst_n)
		row_q == ROW_WRAP |-> col_q == '0) else $error("pending wrap with nonzero column");
	a_sweep_addr: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> addr_s1 <= LAST_CELL) else $error("sweep write beyond last cell");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !q_pop) else $error("command taken during clearing pass");

endmodule

### hw/rtl/text_console_writer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_core
// 80x25 text console with a visible cell buffer and two saved screens.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that fills all three cell
// memories with 0x0500; full stays high meanwhile. Each command is then
// executed by a sequencer over single-write-port cell memories: put char,
// newline, delete and unknown codes go straight to the result stage, read
// cell passes through a read state (registered memory read), and scroll,
// switch screen and clear walk all 2000 cells one per cycle. A two-entry
// command queue sits in front and a one-entry result register behind.
module text_console_writer_core import tcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [2:0]        command,
	input  logic [7:0]        char_code,
	input  logic [1:0]        clear_target,
	input  logic [ADDR_W-1:0] cell_index,
	output logic              empty,
	input  logic              pop,
	output logic [CELL_W-1:0] cell_value,
	output logic [COL_W-1:0]  cursor_column,
	output logic [ROW_W-1:0]  cursor_row,
	output logic              active_screen,
	output logic [ADDR_W-1:0] hw_cursor_position,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data
);

	logic q_wr, q_full, q_valid, q_pop, init_busy;
	cmd_t q_wdata, q_rdata;

	assign cfg_ready = 1'b1;

	tcw_front u_front (
		.push         (push),
		.full         (full),
		.command      (command),
		.char_code    (char_code),
		.clear_target (clear_target),
		.cell_index   (cell_index),
		.q_full       (q_full),
		.init_busy    (init_busy),
		.q_wr         (q_wr),
		.q_data       (q_wdata)
	);

	tcw_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.valid   (q_valid)
	);

	tcw_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.q_valid            (q_valid),
		.cmd                (q_rdata),
		.q_pop              (q_pop),
		.init_busy          (init_busy),
		.cfg_valid          (cfg_valid & cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.empty              (empty),
		.pop                (pop),
		.cell_value         (cell_value),
		.cursor_column      (cursor_column),
		.cursor_row         (cursor_row),
		.active_screen      (active_screen),
		.hw_cursor_position (hw_cursor_position)
	);

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the text console writer against an in-bench console model: every
// command is predicted on model cell buffers and each popped result is
// compared field by field, with random push/pop idling and register changes.
// ----------------------------------------------------------------------------
module tb;
	import tcw_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	logic [2:0]        command;
	logic [7:0]        char_code;
	logic [1:0]        clear_target;
	logic [ADDR_W-1:0] cell_index;
	logic              empty;
	logic              pop;
	logic [CELL_W-1:0] cell_value;
	logic [COL_W-1:0]  cursor_column;
	logic [ROW_W-1:0]  cursor_row;
	logic              active_screen;
	logic [ADDR_W-1:0] hw_cursor_position;
	logic              cfg_valid;
	logic              cfg_ready;
	logic              cfg_index;
	logic [7:0]        cfg_data;

	typedef struct packed {
		logic [CELL_W-1:0] value;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic              scr;
		logic [ADDR_W-1:0] hw;
	} console_result_t;

	// console model state
	logic [CELL_W-1:0] vis_mem [CELLS];
	logic [CELL_W-1:0] scr_mem [2][CELLS];
	int unsigned       col_q, row_q, alt_col, alt_row, hw_q;
	logic              sel_q;
	logic [7:0]        color_q;
	logic              lock_q;

	console_result_t   pending_results[$];
	int                err_count;
	int unsigned       cycle_count;
	bit                quiet;

	text_console_writer_core u_top (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 40_000_000) begin
			$display("tb: errors");
			$finish;
		end
	end

	function automatic logic [CELL_W-1:0] blank_cell(logic [7:0] ch);
		return {color_q, ch};
	endfunction

	function automatic void store_cell(logic [7:0] ch, int unsigned c, int unsigned r);
		int unsigned idx;
		idx = r * COLUMNS + c;
		if (idx >= CELLS)
			return;
		if (!lock_q)
			scr_mem[sel_q][idx] = blank_cell(ch);
		vis_mem[idx] = blank_cell(ch);
	endfunction

	function automatic void scroll_console(logic [7:0] ch);
		for (int i = COLUMNS; i < CELLS; i++)
			vis_mem[i-COLUMNS] = vis_mem[i];
		for (int i = CELLS - COLUMNS; i < CELLS; i++)
			vis_mem[i] = blank_cell(8'd0);
		col_q = 0;
		row_q = ROWS - 1;
		if (ch != CHAR_NEWLINE) begin
			store_cell(ch, 0, row_q);
			col_q = 1;
			hw_q = (ROWS - 1) * COLUMNS + 1;
		end else begin
			hw_q = (ROWS - 1) * COLUMNS;
		end
		for (int i = 0; i < CELLS; i++)
			scr_mem[sel_q][i] = blank_cell(vis_mem[i][7:0]);
	endfunction

	function automatic console_result_t predict_console(logic [2:0] cmd, logic [7:0] ch,
			logic [1:0] tgt, logic [ADDR_W-1:0] cell_idx);
		console_result_t r;
		int unsigned     k;
		r = '0;
		case (cmd)
			CMD_PUT: begin
				if (row_q * COLUMNS + col_q >= CELLS) begin
					scroll_console(ch);
				end else if (ch == CHAR_NEWLINE) begin
					col_q = 0;
					row_q++;
					if (row_q == ROWS)
						scroll_console(CHAR_NEWLINE);
				end else begin
					store_cell(ch, col_q, row_q);
					if (col_q == COLUMNS - 1) begin
						col_q = 0;
						row_q++;
					end else begin
						col_q++;
					end
				end
			end
			CMD_DELETE: begin
				if (col_q != 0 || row_q != 0) begin
					if (col_q == 0) begin
						col_q = COLUMNS - 1;
						row_q--;
					end else begin
						col_q--;
					end
					store_cell(CHAR_SPACE, col_q, row_q);
				end
			end
			CMD_SWITCH: begin
				k = col_q; col_q = alt_col; alt_col = k;
				k = row_q; row_q = alt_row; alt_row = k;
				sel_q = ~sel_q;
				for (int i = 0; i < CELLS; i++)
					vis_mem[i] = blank_cell(scr_mem[sel_q][i][7:0]);
			end
			CMD_CLEAR: begin
				if (tgt == 2'd1 || tgt == 2'd2) begin
					for (int i = 0; i < CELLS; i++)
						scr_mem[tgt == 2'd2][i] = blank_cell(8'd0);
					col_q = 0;
					row_q = 0;
				end
				for (int i = 0; i < CELLS; i++)
					vis_mem[i] = blank_cell(8'd0);
			end
			CMD_READ: begin
				if (cell_idx < CELLS)
					r.value = vis_mem[cell_idx];
			end
			default: ;
		endcase
		r.col = col_q[COL_W-1:0];
		r.row = row_q[ROW_W-1:0];
		r.scr = sel_q;
		r.hw  = hw_q[ADDR_W-1:0];
		return r;
	endfunction

	// result checker
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 20) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				pop <= 1'b1;
			end else begin
				pop <= quiet ? 1'b1 : ($urandom_range(0, 5) != 0);
			end
		end
	end

	always @(posedge clk) begin
		console_result_t e;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result");
				err_count++;
			end else begin
				e = pending_results.pop_front();
				if (cell_value !== e.value) begin
					$error("cell_value exp %h got %h", e.value, cell_value); err_count++;
				end
				if (cursor_column !== e.col) begin
					$error("cursor_column exp %0d got %0d", e.col, cursor_column); err_count++;
				end
				if (cursor_row !== e.row) begin
					$error("cursor_row exp %0d got %0d", e.row, cursor_row); err_count++;
				end
				if (active_screen !== e.scr) begin
					$error("active_screen exp %0d got %0d", e.scr, active_screen); err_count++;
				end
				if (hw_cursor_position !== e.hw) begin
					$error("hw_cursor_position exp %0d got %0d", e.hw, hw_cursor_position);
					err_count++;
				end
			end
		end
	end

	task automatic send_command(logic [2:0] cmd, logic [7:0] ch = 8'd0,
			logic [1:0] tgt = 2'd0, logic [ADDR_W-1:0] cell_idx = '0);
		if (!quiet && $urandom_range(0, 15) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		command      <= cmd;
		char_code    <= ch;
		clear_target <= tgt;
		cell_index   <= cell_idx;
		push         <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		pending_results.push_back(predict_console(cmd, ch, tgt, cell_idx));
		@(negedge clk);
	endtask

	task automatic drain_results();
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2100) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_register(logic idx, logic [7:0] data);
		drain_results();
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_TEXT_COLOR) color_q = data;
		else lock_q = data[0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] random_char();
		return ($urandom_range(0, 9) == 0) ? CHAR_NEWLINE : 8'($urandom);
	endfunction

	task automatic test_directed();
		send_command(CMD_DELETE);                       // delete at home
		send_command(CMD_PUT, 8'hFF);
		send_command(CMD_PUT, 8'h00);
		send_command(CMD_READ, 8'd0, 2'd0, 11'd0);
		send_command(CMD_READ, 8'd0, 2'd0, 11'd1999);
		send_command(CMD_READ, 8'd0, 2'd0, 11'd2000);   // out of range
		send_command(CMD_READ, 8'd0, 2'd0, 11'h7FF);
		send_command(CMD_PUT, CHAR_NEWLINE);
		send_command(CMD_DELETE);                       // back to previous row end
		send_command(CMD_READ, 8'd0, 2'd0, 11'd79);
		send_command(3'd5);
		send_command(3'd7, 8'hA5, 2'd3, 11'h555);
		send_command(CMD_SWITCH);
		send_command(CMD_READ, 8'd0, 2'd0, 11'd0);
		send_command(CMD_SWITCH);
		send_command(CMD_READ, 8'd0, 2'd0, 11'd0);
		send_command(CMD_CLEAR, 8'd0, 2'd3);
		send_command(CMD_CLEAR, 8'd0, 2'd0);
		send_command(CMD_CLEAR, 8'd0, 2'd1);
		send_command(CMD_CLEAR, 8'd0, 2'd2);
	endtask

	task automatic test_wrap_and_scroll();
		// fill past the last row: pending wrap then scroll with char / newline
		for (int i = 0; i < ROWS - 1; i++) send_command(CMD_PUT, CHAR_NEWLINE);
		for (int i = 0; i < COLUMNS; i++) send_command(CMD_PUT, 8'($urandom));
		send_command(CMD_PUT, 8'h41);
		send_command(CMD_READ, 8'd0, 2'd0, 11'd1920);
		send_command(CMD_PUT, CHAR_NEWLINE);            // newline scroll
		for (int i = 0; i < COLUMNS; i++) send_command(CMD_PUT, 8'h42);
		send_command(CMD_PUT, CHAR_NEWLINE);            // newline on pending wrap
		send_command(CMD_SWITCH);
		send_command(CMD_SWITCH);
		send_command(CMD_READ, 8'd0, 2'd0, 11'd1900);
	endtask

	task automatic test_random(int n);
		int unsigned p;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(0, 99);
			if (p < 65)      send_command(CMD_PUT, random_char());
			else if (p < 75) send_command(CMD_DELETE, 8'($urandom), 2'($urandom));
			else if (p < 90) send_command(CMD_READ, 8'($urandom), 2'($urandom),
				($urandom_range(0, 30) == 0) ? 11'($urandom) : 11'($urandom_range(0, 1999)));
			else if (p < 93) send_command(CMD_SWITCH);
			else if (p < 95) send_command(CMD_CLEAR, 8'd0, 2'($urandom));
			else             send_command(3'($urandom_range(5, 7)), 8'($urandom),
				2'($urandom), 11'($urandom));
		end
	endtask

	initial begin
		for (int i = 0; i < CELLS; i++) begin
			vis_mem[i] = RESET_CELL;
			scr_mem[0][i] = RESET_CELL;
			scr_mem[1][i] = RESET_CELL;
		end
		col_q = 0; row_q = 0; alt_col = 0; alt_row = 0; hw_q = 0; sel_q = 0;
		color_q = COLOR_RESET; lock_q = 0;
		err_count = 0; cycle_count = 0; quiet = 0;
		arst_n = 1'b0; push = 1'b0; command = '0; char_code = '0;
		clear_target = '0; cell_index = '0;
		cfg_valid = 1'b0; cfg_index = REG_TEXT_COLOR; cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		write_register(REG_TEXT_COLOR, 8'hFF);
		write_register(REG_MIRROR_LOCK, 8'd1);
		test_wrap_and_scroll();
		test_random(50);
		write_register(REG_TEXT_COLOR, 8'h00);
		test_random(50);
		write_register(REG_MIRROR_LOCK, 8'd0);
		write_register(REG_TEXT_COLOR, 8'h5A);
		test_wrap_and_scroll();
		test_random(50);
		drain_results();                                // hold off until all results arrive
		write_register(REG_TEXT_COLOR, 8'hA5);
		quiet = 1;
		test_random(50);

		drain_results();
		if (err_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
